[rtl/rhsq_pkg.sv]
// Shared widths, codes and state types for the rolling hash substring query block.
// No dependencies; used by rtl/rolling_hash_substring_query_top.sv.
package rhsq_pkg;

	// Field widths
	localparam int FUNC_W = 2;
	localparam int SYM_W  = 5;
	localparam int IDX_W  = 13;
	localparam int HASH_W = 30;
	localparam int STAT_W = 2;

	// Store size: prefix entries 0..MAX_LEN
	localparam int MAX_LEN   = 4096;
	localparam int MEM_DEPTH = MAX_LEN + 1;

	// Polynomial base
	localparam int HASH_BASE = 26;

	// Remainder unit: widest dividend is (m - h) * p + h, below 2^61
	localparam int RED_W     = 2 * HASH_W + 1;
	localparam int CNT_W     = $clog2(RED_W + 1);
	localparam int APP_W     = HASH_W + 5;   // 26 * x + symbol stays below 2^35

	typedef enum logic [FUNC_W-1:0] {
		FUNC_APPEND = 2'd0,
		FUNC_QUERY  = 2'd1,
		FUNC_CLEAR  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_READ = 7'b0000010,
		ST_RED  = 7'b0000100,
		ST_MUL  = 7'b0001000,
		ST_SUM  = 7'b0010000,
		ST_OUT  = 7'b0100000,
		ST_WAIT = 7'b1000000
	} state_t;

	// Which remainder the shared unit is working on
	typedef enum logic [2:0] {
		PH_A = 3'd0,   // h[n] or h[right]
		PH_B = 3'd1,   // p[n] or h[left]
		PH_C = 3'd2,   // p[right-left]
		PH_H = 3'd3,   // final hash
		PH_P = 3'd4    // next power (append)
	} phase_t;

endpackage

[rtl/rolling_hash_substring_query_top.sv]
// Rolling hash store with range query: prefix hash and power memories, one shared
// bit-serial remainder unit and a 30x30 multiplier. Depends on rtl/rhsq_pkg.sv.
//
// Work per request: append does two 30-bit and two 35-bit remainders, query three 30-bit
// and one 61-bit; full, range error, clear and unused codes go straight to the result.
// The remainder unit takes one dividend bit per cycle. One request at a time: the next
// is taken the cycle after the result is loaded. Reset: asynchronous, clears length,
// modulus to 999999937, output empty; memories are not cleared, entry zero reads as
// hash 0 and power 1 unstored.
module rolling_hash_substring_query_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: modulus
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [29:0] cfg_data,     // [29:0] modulus
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,      // [4:0] symbol, [17:5] left, [30:18] right, [31] zero
	input  logic [1:0]  s_tuser,      // [1:0] func
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,      // [29:0] hash_value, [31:30] zero
	output logic [1:0]  m_tuser       // [1:0] status
);

	localparam int IW = rhsq_pkg::IDX_W;
	localparam int HW = rhsq_pkg::HASH_W;
	localparam int RW = rhsq_pkg::RED_W;
	localparam int CW = rhsq_pkg::CNT_W;
	localparam int AW = rhsq_pkg::APP_W;

	localparam logic [29:0] MOD_RESET = 30'd999999937;

	// Prefix hash and power memories
	logic [HW-1:0] ph_mem [rhsq_pkg::MEM_DEPTH];
	logic [HW-1:0] pw_mem [rhsq_pkg::MEM_DEPTH];

	rhsq_pkg::state_t state_q;
	rhsq_pkg::phase_t phase_q;

	logic [HW-1:0] mod_q;
	logic [IW-1:0] len_q;
	logic          is_app_q;
	logic [rhsq_pkg::SYM_W-1:0] sym_q;

	logic [HW-1:0] ph_a_s1, ph_b_s1, pw_s1;
	logic          ha_zero_s1, hb_zero_s1, pw_zero_s1;

	logic [HW-1:0] raw1_q, raw2_q;
	logic [HW-1:0] ra_q, rb_q, rc_q, hash_q;
	logic [2*HW-1:0] mul_q;

	logic [HW-1:0] res_hash_q;
	rhsq_pkg::status_t res_stat_q;

	logic          out_valid_q;
	logic [HW-1:0] out_hash_q;
	rhsq_pkg::status_t out_stat_q;

	// Remainder unit
	logic [RW-1:0] red_sh_q;
	logic [HW-1:0] red_rem_q;
	logic [CW-1:0] red_cnt_q;
	logic          red_start;
	logic [RW-1:0] red_val;
	logic [CW-1:0] red_bits;
	logic          red_done;
	logic [HW:0]   red_t;
	logic [HW-1:0] red_nxt;

	// Request fields
	rhsq_pkg::func_t s_func;
	logic [rhsq_pkg::SYM_W-1:0] s_sym;
	logic [IW-1:0] s_left, s_right;

	logic          accept, full, bad_range, rd_en, wr_en;
	logic [IW-1:0] ha_addr, hb_addr, p_addr, wr_addr;
	logic [HW-1:0] m_eff, raw0_c, raw1_c, raw2_c;
	logic          out_free, out_load;

	assign s_func  = rhsq_pkg::func_t'(s_tuser);
	assign s_sym   = s_tdata[4:0];
	assign s_left  = s_tdata[17:5];
	assign s_right = s_tdata[30:18];

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == rhsq_pkg::ST_IDLE);
	assign accept    = s_tvalid && s_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_hash_q};
	assign m_tuser  = out_stat_q;
	assign out_free = !out_valid_q || m_tready;
	assign out_load = ((state_q == rhsq_pkg::ST_OUT) || (state_q == rhsq_pkg::ST_WAIT)) &&
		out_free;

	// A modulus of zero behaves as one
	assign m_eff = (mod_q == '0) ? HW'(1) : mod_q;

	// Request decode and read addresses
	assign full      = (len_q == IW'(rhsq_pkg::MAX_LEN));
	assign bad_range = (s_left > s_right) || (s_right > len_q);

	always_comb begin
		rd_en   = 1'b0;
		ha_addr = len_q;
		hb_addr = s_left;
		p_addr  = len_q;
		if (accept) begin
			case (s_func)
				rhsq_pkg::FUNC_APPEND: begin
					rd_en = !full;
				end
				rhsq_pkg::FUNC_QUERY: begin
					rd_en   = !bad_range;
					ha_addr = s_right;
					p_addr  = s_right - s_left;
				end
				default: begin
					rd_en = 1'b0;
				end
			endcase
		end
	end

	// Entry zero is never stored: hash 0, power 1
	assign raw0_c = ha_zero_s1 ? '0 : ph_a_s1;
	assign raw2_c = pw_zero_s1 ? HW'(1) : pw_s1;
	assign raw1_c = is_app_q ? raw2_c : (hb_zero_s1 ? '0 : ph_b_s1);

	// Append write-back once the new power is ready
	assign red_done = (red_cnt_q == '0);
	assign wr_en    = (state_q == rhsq_pkg::ST_RED) && red_done &&
		(phase_q == rhsq_pkg::PH_P);
	assign wr_addr  = len_q + IW'(1);

	// Memory ports: registered reads, one write port each
	always_ff @(posedge clk) begin
		if (rd_en) begin
			ph_a_s1 <= ph_mem[ha_addr];
			ph_b_s1 <= ph_mem[hb_addr];
			pw_s1   <= pw_mem[p_addr];
		end
		if (wr_en) begin
			ph_mem[wr_addr] <= hash_q;
			pw_mem[wr_addr] <= red_rem_q;
		end
	end

	// Remainder step: shift in one dividend bit, subtract the modulus if it fits
	assign red_t   = {red_rem_q, red_sh_q[RW-1]};
	assign red_nxt = (red_t >= {1'b0, m_eff}) ? HW'(red_t - {1'b0, m_eff}) : red_t[HW-1:0];

	// Remainder unit start selection
	always_comb begin
		red_start = 1'b0;
		red_val   = '0;
		red_bits  = '0;
		case (state_q)
			rhsq_pkg::ST_READ: begin
				red_start = 1'b1;
				red_val   = {raw0_c, (RW-HW)'(0)};
				red_bits  = CW'(HW);
			end
			rhsq_pkg::ST_RED: begin
				if (red_done) begin
					case (phase_q)
						rhsq_pkg::PH_A: begin
							red_start = 1'b1;
							red_val   = {raw1_q, (RW-HW)'(0)};
							red_bits  = CW'(HW);
						end
						rhsq_pkg::PH_B: begin
							red_start = !is_app_q;
							red_val   = {raw2_q, (RW-HW)'(0)};
							red_bits  = CW'(HW);
						end
						rhsq_pkg::PH_H: begin
							red_start = is_app_q;
							red_val   = {AW'(rb_q) * AW'(rhsq_pkg::HASH_BASE), (RW-AW)'(0)};
							red_bits  = CW'(AW);
						end
						default: begin
							red_start = 1'b0;
						end
					endcase
				end
			end
			rhsq_pkg::ST_SUM: begin
				red_start = 1'b1;
				if (is_app_q) begin
					red_val  = {mul_q[AW-1:0], (RW-AW)'(0)};
					red_bits = CW'(AW);
				end else begin
					red_val  = RW'(mul_q) + RW'(ra_q);
					red_bits = CW'(RW);
				end
			end
			default: begin
				red_start = 1'b0;
			end
		endcase
	end

	// Sequencer, remainder unit and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rhsq_pkg::ST_IDLE;
			phase_q     <= rhsq_pkg::PH_A;
			mod_q       <= MOD_RESET;
			len_q       <= '0;
			is_app_q    <= 1'b0;
			sym_q       <= '0;
			ha_zero_s1  <= 1'b0;
			hb_zero_s1  <= 1'b0;
			pw_zero_s1  <= 1'b0;
			raw1_q      <= '0;
			raw2_q      <= '0;
			ra_q        <= '0;
			rb_q        <= '0;
			rc_q        <= '0;
			hash_q      <= '0;
			mul_q       <= '0;
			res_hash_q  <= '0;
			res_stat_q  <= rhsq_pkg::STAT_OK;
			out_valid_q <= 1'b0;
			out_hash_q  <= '0;
			out_stat_q  <= rhsq_pkg::STAT_OK;
			red_sh_q    <= '0;
			red_rem_q   <= '0;
			red_cnt_q   <= '0;
		end else begin
			// configuration write
			if (cfg_valid && cfg_ready) begin
				mod_q <= cfg_data;
			end

			// remainder unit
			if (red_start) begin
				red_sh_q  <= red_val;
				red_rem_q <= '0;
				red_cnt_q <= red_bits;
			end else if (!red_done) begin
				red_sh_q  <= red_sh_q << 1;
				red_rem_q <= red_nxt;
				red_cnt_q <= red_cnt_q - CW'(1);
			end

			// output register: take a new result, or empty once the result leaves
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_hash_q  <= res_hash_q;
				out_stat_q  <= res_stat_q;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				rhsq_pkg::ST_IDLE: begin
					if (accept) begin
						is_app_q   <= (s_func == rhsq_pkg::FUNC_APPEND);
						sym_q      <= s_sym;
						ha_zero_s1 <= (ha_addr == '0);
						hb_zero_s1 <= (hb_addr == '0);
						pw_zero_s1 <= (p_addr == '0);
						res_hash_q <= '0;
						case (s_func)
							rhsq_pkg::FUNC_APPEND: begin
								if (full) begin
									res_stat_q <= rhsq_pkg::STAT_FULL;
									state_q    <= rhsq_pkg::ST_OUT;
								end else begin
									res_stat_q <= rhsq_pkg::STAT_OK;
									state_q    <= rhsq_pkg::ST_READ;
								end
							end
							rhsq_pkg::FUNC_QUERY: begin
								if (bad_range) begin
									res_stat_q <= rhsq_pkg::STAT_RANGE;
									state_q    <= rhsq_pkg::ST_OUT;
								end else begin
									res_stat_q <= rhsq_pkg::STAT_OK;
									state_q    <= rhsq_pkg::ST_READ;
								end
							end
							rhsq_pkg::FUNC_CLEAR: begin
								res_stat_q <= rhsq_pkg::STAT_OK;
								len_q      <= '0;
								state_q    <= rhsq_pkg::ST_OUT;
							end
							default: begin
								res_stat_q <= rhsq_pkg::STAT_OK;
								state_q    <= rhsq_pkg::ST_OUT;
							end
						endcase
					end
				end
				// memory data valid: keep the second and third operand, reduce the first
				rhsq_pkg::ST_READ: begin
					raw1_q  <= raw1_c;
					raw2_q  <= raw2_c;
					phase_q <= rhsq_pkg::PH_A;
					state_q <= rhsq_pkg::ST_RED;
				end
				rhsq_pkg::ST_RED: begin
					if (red_done) begin
						case (phase_q)
							rhsq_pkg::PH_A: begin
								ra_q    <= red_rem_q;
								phase_q <= rhsq_pkg::PH_B;
							end
							rhsq_pkg::PH_B: begin
								rb_q <= red_rem_q;
								if (is_app_q) begin
									state_q <= rhsq_pkg::ST_MUL;
								end else begin
									phase_q <= rhsq_pkg::PH_C;
								end
							end
							rhsq_pkg::PH_C: begin
								rc_q    <= red_rem_q;
								state_q <= rhsq_pkg::ST_MUL;
							end
							rhsq_pkg::PH_H: begin
								if (is_app_q) begin
									hash_q  <= red_rem_q;
									phase_q <= rhsq_pkg::PH_P;
								end else begin
									res_hash_q <= red_rem_q;
									state_q    <= rhsq_pkg::ST_OUT;
								end
							end
							rhsq_pkg::PH_P: begin
								// memories take the new entry this cycle
								len_q      <= wr_addr;
								res_hash_q <= hash_q;
								state_q    <= rhsq_pkg::ST_OUT;
							end
							default: begin
								state_q <= rhsq_pkg::ST_IDLE;
							end
						endcase
					end
				end
				// append: 26*h + symbol; query: (m - h[left]) * p[right-left]
				rhsq_pkg::ST_MUL: begin
					if (is_app_q) begin
						mul_q <= (2*HW)'(AW'(ra_q) * AW'(rhsq_pkg::HASH_BASE) + AW'(sym_q));
					end else begin
						mul_q <= (2*HW)'(m_eff - rb_q) * (2*HW)'(rc_q);
					end
					state_q <= rhsq_pkg::ST_SUM;
				end
				rhsq_pkg::ST_SUM: begin
					phase_q <= rhsq_pkg::PH_H;
					state_q <= rhsq_pkg::ST_RED;
				end
				// hand the result to the output register when it is free
				rhsq_pkg::ST_OUT: begin
					if (out_free) begin
						state_q <= rhsq_pkg::ST_IDLE;
					end else begin
						state_q <= rhsq_pkg::ST_WAIT;
					end
				end
				rhsq_pkg::ST_WAIT: begin
					if (m_tready) begin
						state_q <= rhsq_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= rhsq_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule
